[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk_i, held off by rst_ni
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression must never be true at a clock edge out of reset
`define ASSERT_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

[rtl/i2sb_pkg.sv]
// ----------------------------------------------------------------------------
// i2sb_pkg
// types, op codes and pixel shift helpers for the interleaved 2bpp blitter
// ----------------------------------------------------------------------------
package i2sb_pkg;

  // frame size must be a power of two, addresses wrap by truncation
  localparam int unsigned FrameBytesDef = 16384;
  localparam int unsigned RowBytesDef   = 80;

  localparam logic [2:0] OP_BEGIN = 3'd0;
  localparam logic [2:0] OP_DRAW  = 3'd1;
  localparam logic [2:0] OP_CLEAR = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_RAW   = 3'd4;

  localparam int unsigned RawAddrW = 14;

  typedef struct packed {
    logic [2:0]          op;
    logic [8:0]          x_pos;
    logic [7:0]          y_pos;
    logic [6:0]          width_bytes;
    logic [7:0]          height_rows;
    logic [7:0]          pixel_byte;
    logic [RawAddrW-1:0] raw_address;
  } in_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } out_t;

  // b >> 2*sh
  function automatic logic [7:0] pix_shr(input logic [7:0] b, input logic [1:0] sh);
    logic [7:0] r;
    case (sh)
      2'd0:    r = b;
      2'd1:    r = {2'b00, b[7:2]};
      2'd2:    r = {4'b0000, b[7:4]};
      default: r = {6'b000000, b[7:6]};
    endcase
    return r;
  endfunction

  // (b << 2*sh) truncated to a byte
  function automatic logic [7:0] pix_shl(input logic [7:0] b, input logic [1:0] sh);
    logic [7:0] r;
    case (sh)
      2'd0:    r = b;
      2'd1:    r = {b[5:0], 2'b00};
      2'd2:    r = {b[3:0], 4'b0000};
      default: r = {b[1:0], 6'b000000};
    endcase
    return r;
  endfunction

  // pixels pushed out on the right, moved to the left of the following byte
  function automatic logic [7:0] pix_spill_left(input logic [7:0] b, input logic [1:0] sh);
    logic [7:0] r;
    case (sh)
      2'd0:    r = 8'h00;
      2'd1:    r = {b[1:0], 6'b000000};
      2'd2:    r = {b[3:0], 4'b0000};
      default: r = {b[5:0], 2'b00};
    endcase
    return r;
  endfunction

  // b >> (8 - 2*sh), zero when no shift
  function automatic logic [7:0] pix_spill_right(input logic [7:0] b, input logic [1:0] sh);
    logic [7:0] r;
    case (sh)
      2'd0:    r = 8'h00;
      2'd1:    r = {6'b000000, b[7:6]};
      2'd2:    r = {4'b0000, b[7:4]};
      default: r = {2'b00, b[7:2]};
    endcase
    return r;
  endfunction

endpackage

[rtl/i2sb_frame_ram.sv]
// ----------------------------------------------------------------------------
// i2sb_frame_ram
// framebuffer store, one write port and one read port, registered read data
// ----------------------------------------------------------------------------
module i2sb_frame_ram #(
  parameter int unsigned FRAME_BYTES = i2sb_pkg::FrameBytesDef
) (
  input  logic                           clk_i,
  input  logic                           wr_en_i,
  input  logic [$clog2(FRAME_BYTES)-1:0] wr_addr_i,
  input  logic [7:0]                     wr_data_i,
  input  logic [$clog2(FRAME_BYTES)-1:0] rd_addr_i,
  output logic [7:0]                     rd_data_o
);
  import i2sb_pkg::*;

  logic [7:0] mem_q [FRAME_BYTES];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/interleaved_2bpp_sprite_blitter_core.sv]
// ----------------------------------------------------------------------------
// interleaved_2bpp_sprite_blitter_core
// sprite blitter over an interleaved 2bpp framebuffer held in one memory
// ----------------------------------------------------------------------------
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o | in_item_i  (i2sb_pkg::in_t)
//   out     | output    | out_valid_o/out_ready_i | out_item_o (i2sb_pkg::out_t)
//
// draw, clear, read and raw read items use the single read port for the current
// byte and then the following byte, so no item is accepted while stage 1 holds
// one; begin and ignored items do not enter the stages.
// a result passes through stage 1 and stage 2 into a two-entry output queue.
// after reset a clearing pass zeroes the framebuffer, one byte a cycle, with in_ready_o low.
// input stalls when the output queue plus the result in flight would overflow.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module interleaved_2bpp_sprite_blitter_core #(
  parameter int unsigned FRAME_BYTES = i2sb_pkg::FrameBytesDef,
  parameter int unsigned ROW_BYTES   = i2sb_pkg::RowBytesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  i2sb_pkg::in_t  in_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output i2sb_pkg::out_t out_item_o
);
  import i2sb_pkg::*;

  localparam int unsigned AddrW = $clog2(FRAME_BYTES);
  localparam logic [AddrW-1:0] BankOffset = AddrW'(FRAME_BYTES / 2);
  localparam logic [AddrW-1:0] RowStep    = AddrW'(ROW_BYTES);

  // clearing pass
  logic             clr_busy_q;
  logic [AddrW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + AddrW'(1);
      if (clr_addr_q == {AddrW{1'b1}}) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // rectangle geometry and walk position
  logic [1:0]       shift_q, shift_d;
  logic [6:0]       width_q, width_d;
  logic [6:0]       half_q, half_d;
  logic [AddrW-1:0] odd_start_q, odd_start_d;
  logic [AddrW-1:0] bank_start_q, bank_start_d;
  logic [6:0]       col_q, col_d;
  logic [6:0]       row_q, row_d;
  logic             second_q, second_d;
  logic [7:0]       prev_q, prev_d;

  // stage 1: current byte back from memory
  logic             s1_valid_q;
  logic [2:0]       s1_op_q;
  logic [AddrW-1:0] s1_cur_q, s1_nxt_q;
  logic             s1_col0_q, s1_row_end_q, s1_last_q;
  logic [7:0]       s1_pix_q, s1_prev_q;

  // stage 2: following byte back from memory
  logic             s2_valid_q;
  logic [2:0]       s2_op_q;
  logic [AddrW-1:0] s2_nxt_q;
  logic             s2_row_end_q, s2_last_q;
  logic [7:0]       s2_pix_q, s2_cur_old_q;

  // output queue
  out_t       fifo_q [2];
  logic       fifo_wp_q, fifo_rp_q;
  logic [1:0] fifo_cnt_q;

  // memory ports
  logic             wr_en;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [7:0]       wr_data, rd_data;
  logic             fwd_hit_q;
  logic [7:0]       fwd_data_q;
  logic [7:0]       mem_byte;

  logic in_fire, is_rect_op, rect_active, do_rect, do_raw, do_begin;
  logic [AddrW-1:0] cur_addr, nxt_addr;
  logic [7:0]       col_inc, row_inc;
  logic             row_end, bank_done, last_flag;
  logic [AddrW-1:0] start_lin, start_addr, odd_addr;
  logic [AddrW+RawAddrW-1:0] raw_ext;

  logic       s1_wr, s2_wr, s2_res, push, pop;
  logic [7:0] keep_l, keep_r, s1_new, s2_new;
  out_t       s2_out;

  i2sb_frame_ram #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  // ---------------- accept side ----------------
  assign s2_res     = s2_valid_q && (s2_op_q == OP_READ || s2_op_q == OP_RAW);
  assign in_ready_o = !clr_busy_q && !s1_valid_q && ((fifo_cnt_q + 2'(s2_res)) < 2'd2);
  assign in_fire    = in_valid_i && in_ready_o;

  assign is_rect_op  = (in_item_i.op == OP_DRAW) || (in_item_i.op == OP_CLEAR) ||
                       (in_item_i.op == OP_READ);
  assign rect_active = (width_q != 7'd0) && (half_q != 7'd0) &&
                       !(second_q && (row_q >= half_q));
  assign do_rect  = in_fire && is_rect_op && rect_active;
  assign do_raw   = in_fire && (in_item_i.op == OP_RAW);
  assign do_begin = in_fire && (in_item_i.op == OP_BEGIN);

  assign cur_addr  = bank_start_q + AddrW'(col_q);
  assign nxt_addr  = cur_addr + AddrW'(1);
  assign col_inc   = {1'b0, col_q} + 8'd1;
  assign row_inc   = {1'b0, row_q} + 8'd1;
  assign row_end   = (col_inc == {1'b0, width_q});
  assign bank_done = (row_inc >= {1'b0, half_q});
  assign last_flag = row_end && bank_done && second_q;

  // even rows from y/2, odd pixel rows live in the upper bank
  assign start_lin  = AddrW'({1'b0, in_item_i.y_pos[7:1]}) * RowStep +
                      AddrW'(in_item_i.x_pos[8:2]);
  assign start_addr = start_lin | (in_item_i.y_pos[0] ? BankOffset : '0);
  assign odd_addr   = (start_addr + (in_item_i.y_pos[0] ? RowStep : '0)) ^ BankOffset;
  assign raw_ext    = {{AddrW{1'b0}}, in_item_i.raw_address};

  always_comb begin
    shift_d      = shift_q;
    width_d      = width_q;
    half_d       = half_q;
    odd_start_d  = odd_start_q;
    bank_start_d = bank_start_q;
    col_d        = col_q;
    row_d        = row_q;
    second_d     = second_q;
    prev_d       = prev_q;
    if (do_begin) begin
      shift_d      = in_item_i.x_pos[1:0];
      width_d      = in_item_i.width_bytes;
      half_d       = in_item_i.height_rows[7:1];
      odd_start_d  = odd_addr;
      bank_start_d = start_addr;
      col_d        = '0;
      row_d        = '0;
      second_d     = 1'b0;
      prev_d       = '0;
    end else if (do_rect) begin
      if (in_item_i.op == OP_DRAW) begin
        prev_d = in_item_i.pixel_byte;
      end
      if (row_end) begin
        col_d        = '0;
        row_d        = row_inc[6:0];
        bank_start_d = bank_start_q + RowStep;
        if (bank_done && !second_q) begin
          second_d     = 1'b1;
          row_d        = '0;
          bank_start_d = odd_start_q;
        end
      end else begin
        col_d = col_inc[6:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q      <= '0;
      width_q      <= '0;
      half_q       <= '0;
      odd_start_q  <= '0;
      bank_start_q <= '0;
      col_q        <= '0;
      row_q        <= '0;
      second_q     <= 1'b0;
      prev_q       <= '0;
    end else begin
      shift_q      <= shift_d;
      width_q      <= width_d;
      half_q       <= half_d;
      odd_start_q  <= odd_start_d;
      bank_start_q <= bank_start_d;
      col_q        <= col_d;
      row_q        <= row_d;
      second_q     <= second_d;
      prev_q       <= prev_d;
    end
  end

  // ---------------- memory access ----------------
  // stage 1 owns the read port for its following byte, so no accept then
  always_comb begin
    if (s1_valid_q) begin
      rd_addr = s1_nxt_q;
    end else if (do_raw) begin
      rd_addr = raw_ext[AddrW-1:0];
    end else begin
      rd_addr = cur_addr;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = s1_cur_q;
    wr_data = s1_new;
    if (clr_busy_q) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_q;
      wr_data = 8'h00;
    end else if (s1_wr) begin
      wr_en   = 1'b1;
      wr_addr = s1_cur_q;
      wr_data = s1_new;
    end else if (s2_wr) begin
      wr_en   = 1'b1;
      wr_addr = s2_nxt_q;
      wr_data = s2_new;
    end
  end

  // bypass a write that lands in the same cycle as the read of that byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else begin
      fwd_hit_q <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= wr_data;
  end

  assign mem_byte = fwd_hit_q ? fwd_data_q : rd_data;

  // ---------------- stage 1 ----------------
  assign keep_l = pix_spill_left(8'hFF, shift_q);
  assign keep_r = pix_shr(8'hFF, shift_q);
  assign s1_wr  = s1_valid_q && (s1_op_q == OP_DRAW || s1_op_q == OP_CLEAR);

  always_comb begin
    if (s1_op_q == OP_DRAW) begin
      if (s1_col0_q) begin
        s1_new = pix_shr(s1_pix_q, shift_q) | (mem_byte & keep_l);
      end else begin
        s1_new = pix_shr(s1_pix_q, shift_q) | pix_spill_left(s1_prev_q, shift_q);
      end
    end else begin
      s1_new = s1_col0_q ? (mem_byte & keep_l) : 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= do_rect || do_raw;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_rect || do_raw) begin
      s1_op_q      <= in_item_i.op;
      s1_cur_q     <= cur_addr;
      s1_nxt_q     <= nxt_addr;
      s1_col0_q    <= (col_q == 7'd0);
      s1_row_end_q <= row_end && !do_raw;
      s1_last_q    <= last_flag && !do_raw;
      s1_pix_q     <= in_item_i.pixel_byte;
      s1_prev_q    <= prev_q;
    end
    if (s1_valid_q) begin
      s2_op_q      <= s1_op_q;
      s2_nxt_q     <= s1_nxt_q;
      s2_row_end_q <= s1_row_end_q;
      s2_last_q    <= s1_last_q;
      s2_pix_q     <= s1_pix_q;
      s2_cur_old_q <= mem_byte;
    end
  end

  // ---------------- stage 2 ----------------
  assign s2_wr = s2_valid_q && s2_row_end_q && (s2_op_q == OP_DRAW || s2_op_q == OP_CLEAR);

  always_comb begin
    if (s2_op_q == OP_DRAW) begin
      s2_new = pix_spill_left(s2_pix_q, shift_q) | (mem_byte & keep_r);
    end else begin
      s2_new = mem_byte & keep_r;
    end
  end

  always_comb begin
    if (s2_op_q == OP_RAW) begin
      s2_out.value = s2_cur_old_q;
      s2_out.last  = 1'b0;
    end else begin
      s2_out.value = pix_spill_right(mem_byte, shift_q) | pix_shl(s2_cur_old_q, shift_q);
      s2_out.last  = s2_last_q;
    end
  end

  // ---------------- output queue ----------------
  assign push = s2_res;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fifo_wp_q  <= 1'b0;
      fifo_rp_q  <= 1'b0;
      fifo_cnt_q <= '0;
    end else begin
      if (push) begin
        fifo_wp_q <= !fifo_wp_q;
      end
      if (pop) begin
        fifo_rp_q <= !fifo_rp_q;
      end
      fifo_cnt_q <= fifo_cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[fifo_wp_q] <= s2_out;
    end
  end

  assign out_valid_o = (fifo_cnt_q != 2'd0);
  assign out_item_o  = fifo_q[fifo_rp_q];

  // ---------------- assertions ----------------
  `ASSERT_NEVER(a_single_write, s1_wr && s2_wr, "both stages write the frame store")
  `ASSERT_CLK(a_s1_spacing, s1_valid_q |=> !s1_valid_q && s2_valid_q, "stage 1 items too close")
  `ASSERT_NEVER(a_fifo_overflow, push && !pop && (fifo_cnt_q == 2'd2), "output queue overflow")
  `ASSERT_CLK(a_no_work_in_clear, clr_busy_q |-> !s1_valid_q && !s2_valid_q, "item during clear")

endmodule

[tb/sv/interleaved_2bpp_sprite_blitter_checker.sv]
// ----------------------------------------------------------------------------
// interleaved_2bpp_sprite_blitter_checker
// watches both channels of the blitter, keeps a mirror of the framebuffer and
// the rectangle walk, and compares every returned byte against the prediction
// ----------------------------------------------------------------------------
module interleaved_2bpp_sprite_blitter_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  i2sb_pkg::in_t  in_item_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  i2sb_pkg::out_t out_item_i,
  output int unsigned    fail_count_o,
  output int unsigned    pending_o
);
  import i2sb_pkg::*;

  localparam int unsigned FrameBytes = FrameBytesDef;
  localparam int unsigned RowBytes   = RowBytesDef;
  localparam int unsigned BankOffset = FrameBytes / 2;
  localparam int unsigned AddrW      = $clog2(FrameBytes);

  typedef struct packed {
    bit [1:0]       shift;
    bit [6:0]       width;
    bit [6:0]       rows_per_bank;
    bit [AddrW-1:0] even_base;
    bit [AddrW-1:0] odd_base;
  } rect_t;

  bit [7:0]       pix_mem [FrameBytes];
  rect_t          rect;
  bit [AddrW-1:0] row_base;
  bit [6:0]       col_idx;
  bit [6:0]       row_idx;
  bit             odd_pass;
  bit [7:0]       last_sprite;
  out_t           expected_reads [$];
  int unsigned    fail_count;
  int unsigned    outstanding;

  assign fail_count_o = fail_count;
  assign pending_o    = outstanding;

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic bit rect_open();
    if (rect.width == 0 || rect.rows_per_bank == 0) return 1'b0;
    return !(odd_pass && row_idx >= rect.rows_per_bank);
  endfunction

  task automatic expect_read(input bit [7:0] value, input bit last);
    out_t res;
    res.value = value;
    res.last  = last;
    expected_reads.push_back(res);
    outstanding++;
  endtask

  // advance the walk by one byte, returns 1 when the rectangle is done
  function automatic bit step_position();
    bit done;
    done = 1'b0;
    col_idx = col_idx + 1'b1;
    if (col_idx >= rect.width) begin
      col_idx  = '0;
      row_idx  = row_idx + 1'b1;
      row_base = AddrW'(row_base + RowBytes);
      if (row_idx >= rect.rows_per_bank) begin
        if (!odd_pass) begin
          odd_pass = 1'b1;
          row_idx  = '0;
          row_base = rect.odd_base;
        end else begin
          done = 1'b1;
        end
      end
    end
    return done;
  endfunction

  task automatic apply_blit(input in_t item);
    int unsigned    s2;
    int unsigned    origin;
    bit [AddrW-1:0] cur;
    bit [AddrW-1:0] nxt;
    bit [7:0]       keep_left;
    bit [7:0]       keep_right;
    bit [7:0]       b;
    bit [7:0]       rd;
    bit             done;
    rd = '0;
    if (item.op == OP_BEGIN) begin
      origin = (32'(item.y_pos) >> 1) * RowBytes + (32'(item.x_pos) >> 2);
      if (item.y_pos[0]) origin = origin | BankOffset;
      rect.shift         = item.x_pos[1:0];
      rect.width         = item.width_bytes;
      rect.rows_per_bank = item.height_rows[7:1];
      rect.even_base     = AddrW'(origin);
      rect.odd_base      = AddrW'((origin + (item.y_pos[0] ? RowBytes : 0)) ^ BankOffset);
      row_base    = rect.even_base;
      col_idx     = '0;
      row_idx     = '0;
      odd_pass    = 1'b0;
      last_sprite = '0;
    end else if (item.op == OP_RAW) begin
      expect_read(pix_mem[AddrW'(item.raw_address)], 1'b0);
    end else if (item.op <= OP_READ && rect_open()) begin
      s2         = 2 * rect.shift;
      cur        = AddrW'(row_base + col_idx);
      nxt        = AddrW'(cur + 1);
      keep_left  = 8'(32'hFF << (8 - s2));
      keep_right = 8'(32'hFF >> s2);
      case (item.op)
        OP_DRAW: begin
          b = item.pixel_byte;
          if (col_idx == 0) begin
            pix_mem[cur] = 8'(32'(b) >> s2) | (pix_mem[cur] & keep_left);
          end else begin
            pix_mem[cur] = 8'((32'(b) >> s2) | (32'(last_sprite) << (8 - s2)));
          end
          last_sprite = b;
          // trailing partial byte at the row end
          if (32'(col_idx) + 1 == 32'(rect.width)) begin
            pix_mem[nxt] = 8'(32'(b) << (8 - s2)) | (pix_mem[nxt] & keep_right);
          end
        end
        OP_CLEAR: begin
          if (col_idx == 0) pix_mem[cur] = pix_mem[cur] & keep_left;
          else pix_mem[cur] = '0;
          if (32'(col_idx) + 1 == 32'(rect.width)) pix_mem[nxt] = pix_mem[nxt] & keep_right;
        end
        default: begin
          rd = 8'((32'(pix_mem[nxt]) >> (8 - s2)) | (32'(pix_mem[cur]) << s2));
        end
      endcase
      done = step_position();
      if (item.op == OP_READ) expect_read(rd, done);
    end
  endtask

  task automatic check_read(input out_t got);
    out_t want;
    if (expected_reads.size() == 0) begin
      report_mismatch($sformatf("unexpected transaction value=%h last=%b", got.value, got.last));
    end else begin
      want = expected_reads.pop_front();
      outstanding--;
      if (got.value !== want.value) begin
        report_mismatch($sformatf("value got %h want %h", got.value, want.value));
      end
      if (got.last !== want.last) begin
        report_mismatch($sformatf("last got %b want %b (value %h)", got.last, want.last,
                                  want.value));
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) check_read(out_item_i);
      if (in_valid_i && in_ready_i) apply_blit(in_item_i);
    end
  end

endmodule

[tb/sv/tb_interleaved_2bpp_sprite_blitter_core.sv]
// ----------------------------------------------------------------------------
// tb_interleaved_2bpp_sprite_blitter_core
// drives begin, draw, clear, read and raw read transactions into the blitter:
// a directed opening over the corner cases, then random rectangle walks and
// noise under several idle and stall mixes; the checker does the comparing
// ----------------------------------------------------------------------------
module tb_interleaved_2bpp_sprite_blitter_core;
  import i2sb_pkg::*;

  localparam logic [2:0]  OP_MAX        = 3'd7;
  localparam int unsigned TimeoutCycles = 600000;
  localparam int unsigned PhaseItems    = 270;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_t         in_item_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_item_o;

  int unsigned fail_count;
  int unsigned reads_pending;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned rx_hold;
  int unsigned items_sent;
  int unsigned cycle_count;

  interleaved_2bpp_sprite_blitter_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  interleaved_2bpp_sprite_blitter_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_i  (out_item_o),
    .fail_count_o(fail_count),
    .pending_o   (reads_pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > TimeoutCycles) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off in the squeezed phase
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (rx_hold != 0) begin
      out_ready_i <= 1'b0;
      rx_hold--;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // unused fields carry random junk
  function automatic in_t junk_item(input logic [2:0] op);
    in_t it;
    it.op          = op;
    it.x_pos       = 9'($urandom);
    it.y_pos       = 8'($urandom);
    it.width_bytes = 7'($urandom);
    it.height_rows = 8'($urandom);
    it.pixel_byte  = 8'($urandom);
    it.raw_address = RawAddrW'($urandom);
    return it;
  endfunction

  function automatic in_t begin_item(input int unsigned x, input int unsigned y,
                                     input int unsigned w, input int unsigned h);
    in_t it;
    it             = junk_item(OP_BEGIN);
    it.x_pos       = 9'(x);
    it.y_pos       = 8'(y);
    it.width_bytes = 7'(w);
    it.height_rows = 8'(h);
    return it;
  endfunction

  function automatic in_t byte_item(input logic [2:0] op, input logic [7:0] b);
    in_t it;
    it            = junk_item(op);
    it.pixel_byte = b;
    return it;
  endfunction

  function automatic in_t raw_item(input int unsigned addr);
    in_t it;
    it             = junk_item(OP_RAW);
    it.raw_address = RawAddrW'(addr);
    return it;
  endfunction

  function automatic int unsigned rect_origin(input int unsigned x, input int unsigned y);
    return ((y >> 1) * RowBytesDef + (x >> 2)) | ((y % 2) ? FrameBytesDef / 2 : 0);
  endfunction

  task automatic push_item(input in_t item);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    if (item.op <= OP_RAW) items_sent++;
  endtask

  task automatic walk_rect(input int unsigned n, input bit reads_only);
    int unsigned r;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (reads_only || r >= 65) push_item(byte_item(OP_READ, 8'($urandom)));
      else if (r < 50) push_item(byte_item(OP_DRAW, 8'($urandom)));
      else push_item(byte_item(OP_CLEAR, 8'($urandom)));
    end
  endtask

  // well-formed rectangle: begin, walk, then maybe read it back and raw-read near its origin
  task automatic random_blit();
    int unsigned x;
    int unsigned y;
    int unsigned w;
    int unsigned h;
    int unsigned n;
    int unsigned full;
    x = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 319);
    y = $urandom_range(0, 199);
    w = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
    h = $urandom_range(2, 8);
    full = w * (h / 2) * 2;
    n = full;
    if ($urandom_range(0, 4) == 0) n = $urandom_range(0, full);
    else if ($urandom_range(0, 7) == 0) n = full + $urandom_range(1, 3);
    push_item(begin_item(x, y, w, h));
    walk_rect(n, 1'b0);
    if ($urandom_range(0, 99) < 40) begin
      push_item(begin_item(x, y, w, h));
      walk_rect(full, 1'b1);
    end
    if ($urandom_range(0, 99) < 30) begin
      repeat ($urandom_range(1, 4)) begin
        push_item(raw_item(rect_origin(x, y) + $urandom_range(0, w + RowBytesDef)));
      end
    end
  endtask

  task automatic random_noise();
    logic [2:0] op;
    op = 3'($urandom_range(0, OP_MAX));
    if (op == OP_BEGIN) begin
      // wide-range geometry, then a partial walk
      push_item(begin_item($urandom_range(0, 511), $urandom_range(0, 255),
                           $urandom_range(0, 127), $urandom_range(0, 255)));
      walk_rect($urandom_range(0, 12), 1'b0);
    end else if (op == OP_RAW) begin
      push_item(raw_item($urandom));
    end else begin
      push_item(junk_item(op));
    end
  endtask

  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input bit squeeze);
    int unsigned goal;
    idle_pct  = idle;
    stall_pct = stall;
    goal      = items_sent + PhaseItems;
    if (squeeze) begin
      // receiver holds off while reads keep coming, so the input backs up
      rx_hold = 300;
      repeat (24) push_item(raw_item($urandom));
      push_item(begin_item(4, 10, 3, 4));
      walk_rect(12, 1'b1);
    end
    while (items_sent < goal) begin
      if ($urandom_range(0, 99) < 75) random_blit();
      else random_noise();
    end
  endtask

  initial begin
    idle_pct  = 0;
    stall_pct = 0;
    rx_hold   = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed opening
    push_item(raw_item(0));
    // empty rectangle: zero width
    push_item(begin_item(0, 0, 0, 4));
    push_item(byte_item(OP_DRAW, 8'hFF));
    push_item(byte_item(OP_READ, 8'h00));
    // empty rectangle: a single row
    push_item(begin_item(3, 2, 1, 1));
    push_item(byte_item(OP_DRAW, 8'hFF));
    // odd start row, one byte per bank, then a transaction past the end
    push_item(begin_item(5, 1, 1, 2));
    push_item(byte_item(OP_DRAW, 8'hFF));
    push_item(byte_item(OP_DRAW, 8'hA5));
    push_item(byte_item(OP_READ, 8'h00));
    push_item(begin_item(5, 1, 1, 2));
    push_item(byte_item(OP_READ, 8'h00));
    push_item(byte_item(OP_READ, 8'h00));
    // no shift; clear between draws leaves the previous sprite byte alone
    push_item(begin_item(0, 0, 2, 2));
    push_item(byte_item(OP_DRAW, 8'h81));
    push_item(byte_item(OP_CLEAR, 8'h00));
    push_item(byte_item(OP_DRAW, 8'h7E));
    push_item(byte_item(OP_READ, 8'h00));
    // geometry far outside the screen wraps
    push_item(begin_item(511, 255, 127, 255));
    push_item(byte_item(OP_DRAW, 8'hFF));
    push_item(byte_item(OP_READ, 8'h00));
    push_item(junk_item(OP_MAX));
    push_item(raw_item(FrameBytesDef - 1));
    push_item(raw_item(FrameBytesDef / 2));
    push_item(raw_item(rect_origin(5, 1)));

    run_phase(0, 0, 1'b1);
    run_phase(78, 0, 1'b0);
    run_phase(0, 78, 1'b0);
    run_phase(10, 10, 1'b0);

    in_valid_i <= 1'b0;
    while (reads_pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
